@@ hw/rtl/baro_pkg.sv @@
// Shared types, widths and constants for the barometric altitude pipeline.
// Also holds the constant function that computes each entry of the fractional log table.
// No dependencies.
`timescale 1ns / 1ps

package baro_pkg;

    localparam int BARO_LOG_TABLE_BITS = 8;

    // Field widths.
    localparam int P_W        = 17;
    localparam int T_W        = 15;
    localparam int TS_W       = 64;
    localparam int ALT_W      = 25;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;

    // Internal widths.
    localparam int LN_W    = 20;   // ln() in Q16, at most 17 * ln2
    localparam int KEL_W   = 16;   // temperature in centi-Kelvin
    localparam int KS_W    = 37;   // scale factor times centi-Kelvin
    localparam int PROD_W  = 57;   // full scaled product in Q32

    // Pipeline geometry.
    localparam int LN_STAGES = 5;
    localparam int DEPTH     = 8;

    localparam logic [15:0]              LN2_Q16      = 16'd45426;
    localparam logic [31:0]              LN2_Q32      = 32'd2977044472;
    localparam logic [20:0]              SCALE_Q16    = 21'd1918322;
    localparam logic signed [16:0]       KELVIN_CENTI = 17'sd27300;
    localparam logic signed [ALT_W-1:0]  ALT_MIN      = -25'sd200000;
    localparam logic signed [ALT_W-1:0]  ALT_MAX      = 25'sd15000000;
    localparam logic [P_W-1:0]           SLP_RESET    = 17'd101325;

    // ln(x) in Q16 for x in [1,2) given in Q30, by bitwise log2 and a
    // multiplication by ln2. Evaluated only at elaboration.
    function automatic logic [15:0] f_ln_frac_entry(input logic [30:0] x);
        logic [63:0] y;
        logic [63:0] acc;
        logic [63:0] p;
        y   = 64'(x);
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            y   = (y * y) >> 30;
            acc = acc << 1;
            if (y >= 64'h0000_0000_8000_0000) begin
                y   = y >> 1;
                acc = acc | 64'd1;
            end
        end
        p = acc * 64'(LN2_Q32) + 64'h0000_8000_0000_0000;
        return p[63:48];
    endfunction

endpackage

@@ hw/rtl/baro_ln.sv @@
// Five-stage pipelined natural logarithm in Q16 of a 17-bit unsigned value.
// Uses baro_pkg for widths and the table-entry function.
`timescale 1ns / 1ps

module baro_ln #(
    parameter int LOG_TABLE_BITS = baro_pkg::BARO_LOG_TABLE_BITS
) (
    input  logic                          i_clk,
    input  logic [baro_pkg::LN_STAGES-1:0] i_en,
    input  logic [baro_pkg::P_W-1:0]      i_value,
    output logic [baro_pkg::LN_W-1:0]     o_ln
);
    import baro_pkg::*;

    localparam int SH       = 30 - LOG_TABLE_BITS;
    localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;
    localparam int IDX_W    = LOG_TABLE_BITS + 1;
    localparam int DR_W     = 16 + SH;

    typedef logic [TAB_SIZE-1:0][15:0] t_tab;

    function automatic t_tab f_build();
        t_tab tab;
        for (int k = 0; k < TAB_SIZE - 1; k++) begin
            tab[k] = f_ln_frac_entry(31'((1 << 30) + (k << SH)));
        end
        tab[TAB_SIZE-1] = LN2_Q16;
        return tab;
    endfunction

    localparam t_tab LOG_TAB = f_build();

    // Stage 0: leading-one position.
    logic [4:0]     w_e;
    logic [P_W-1:0] r_v;
    logic [4:0]     r_e0;

    always_comb begin
        w_e = '0;
        for (int i = 0; i < P_W; i++) begin
            if (i_value[i]) begin
                w_e = 5'(i);
            end
        end
    end

    // Stage 1: normalize to a Q30 mantissa in [1,2) and keep the fraction.
    logic [30:0] w_m;
    logic [29:0] r_f;
    logic [4:0]  r_e1;

    assign w_m = {14'd0, r_v} << (5'd30 - r_e0);

    // Stage 2: table lookup of the two bracketing entries.
    logic [IDX_W-1:0] w_idx;
    logic [15:0]      w_lo;
    logic [15:0]      w_hi;
    logic [15:0]      r_lo;
    logic [15:0]      r_d;
    logic [SH-1:0]    r_rem;
    logic [4:0]       r_e2;

    assign w_idx = {1'b0, r_f[29:SH]};
    assign w_lo  = LOG_TAB[w_idx];
    assign w_hi  = LOG_TAB[w_idx + IDX_W'(1)];

    // Stage 3: exponent term and interpolation product.
    logic [DR_W-1:0] w_dr;
    logic [LN_W-1:0] r_base;
    logic [15:0]     r_frac;

    assign w_dr = DR_W'(r_d) * DR_W'(r_rem);

    // Stage 4: final sum.
    logic [LN_W-1:0] r_ln;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v  <= i_value;
            r_e0 <= w_e;
        end
        if (i_en[1]) begin
            r_f  <= w_m[29:0];
            r_e1 <= r_e0;
        end
        if (i_en[2]) begin
            r_lo  <= w_lo;
            r_d   <= (w_hi >= w_lo) ? (w_hi - w_lo) : 16'd0;
            r_rem <= r_f[SH-1:0];
            r_e2  <= r_e1;
        end
        if (i_en[3]) begin
            r_base <= LN_W'(r_e2) * LN_W'(LN2_Q16) + LN_W'(r_lo);
            r_frac <= w_dr[DR_W-1:SH];
        end
        if (i_en[4]) begin
            r_ln <= r_base + LN_W'(r_frac);
        end
    end

    assign o_ln = r_ln;

endmodule

@@ hw/rtl/barometric_altitude.sv @@
// Top level of the barometric altitude pipeline: stream ports, the sea-level
// pressure register, two baro_ln instances and the scaling and clipping stages.
// An accepted item moves stage by stage into the output register, the last stage.
// Throughput is one item per cycle while the output is taken; each of
// the 8 stages holds one item and fills bubbles independently, so the rate is set
// only by the output handshake.
// Reset (synchronous, active low) empties the pipeline and sets P0 to 101325 Pa.
`timescale 1ns / 1ps

module barometric_altitude #(
    parameter int LOG_TABLE_BITS = baro_pkg::BARO_LOG_TABLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [baro_pkg::P_W-1:0]        i_cfg_wr_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // pressure_pa[16:0], temperature_centi[31:17], sample_time[95:32]
    input  logic [baro_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // altitude_cm[24:0], result_time[88:25], zero padding[95:89]
    output logic [baro_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // saturated[0]
    output logic                            o_m_axis_tuser
);
    import baro_pkg::*;

    localparam int PAD_W = OUT_DATA_W - ALT_W - TS_W;
    localparam logic signed [ALT_W:0] LIM_MAX = (ALT_W + 1)'(ALT_MAX);
    localparam logic signed [ALT_W:0] LIM_MIN = (ALT_W + 1)'(ALT_MIN);

    logic [P_W-1:0]  w_p;
    logic [T_W-1:0]  w_t;
    logic [TS_W-1:0] w_ts;

    assign w_p  = i_s_axis_tdata[P_W-1:0];
    assign w_t  = i_s_axis_tdata[P_W+T_W-1:P_W];
    assign w_ts = i_s_axis_tdata[P_W+T_W+TS_W-1:P_W+T_W];

    // Sea-level pressure register.
    logic [P_W-1:0] r_p0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= SLP_RESET;
        end else if (i_cfg_wr_en) begin
            r_p0 <= i_cfg_wr_data;
        end
    end

    // Stage valid bits and per-stage advance; a stage moves when it is empty
    // or the stage after it moves.
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH:0]   w_en;

    always_comb begin
        w_en[DEPTH] = i_m_axis_tready;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[DEPTH-1];

    // Logarithms of P and P0.
    logic [LN_W-1:0] w_ln_p;
    logic [LN_W-1:0] w_ln_0;

    baro_ln #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_ln_p (
        .i_clk  (i_clk),
        .i_en   (w_en[LN_STAGES-1:0]),
        .i_value(w_p),
        .o_ln   (w_ln_p)
    );

    baro_ln #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_ln_0 (
        .i_clk  (i_clk),
        .i_en   (w_en[LN_STAGES-1:0]),
        .i_value(r_p0),
        .o_ln   (w_ln_0)
    );

    // Side data traveling beside the log pipelines.
    logic signed [16:0]  w_kel_s;
    logic [KEL_W-1:0]    r_kel;
    logic [KS_W-1:0]     r_ks   [1:LN_STAGES];
    logic [TS_W-1:0]     r_time [0:DEPTH-1];
    logic                r_zp   [0:DEPTH-2];
    logic                r_z0   [0:DEPTH-2];

    // Temperature is at least -163.84 C, so the Kelvin sum is always positive.
    assign w_kel_s = KELVIN_CENTI + 17'($signed(w_t));

    // Difference of logs and its magnitude.
    logic signed [LN_W:0] w_diff;
    logic                 r_neg5;
    logic [LN_W-1:0]      r_mag;

    assign w_diff = $signed({1'b0, w_ln_p}) - $signed({1'b0, w_ln_0});

    // Scaled product, rounding and clipping.
    logic                    r_neg6;
    logic [PROD_W-1:0]       r_prod;
    logic [PROD_W-1:0]       w_rnd;
    logic signed [ALT_W:0]   w_cm;
    logic signed [ALT_W:0]   w_alt;
    logic [ALT_W-1:0]        n_alt;
    logic                    n_sat;
    logic [ALT_W-1:0]        r_alt;
    logic                    r_sat;

    assign w_rnd = r_prod + PROD_W'(64'h0000_0000_8000_0000);
    assign w_cm  = $signed({1'b0, w_rnd[PROD_W-1:32]});
    // A negative log means the sample is above the reference level.
    assign w_alt = r_neg6 ? w_cm : -w_cm;

    always_comb begin
        n_alt = w_alt[ALT_W-1:0];
        n_sat = 1'b0;
        if (r_zp[DEPTH-2]) begin
            n_alt = ALT_MAX;
            n_sat = 1'b1;
        end else if (r_z0[DEPTH-2]) begin
            n_alt = ALT_MIN;
            n_sat = 1'b1;
        end else if (w_alt > LIM_MAX) begin
            n_alt = ALT_MAX;
            n_sat = 1'b1;
        end else if (w_alt < LIM_MIN) begin
            n_alt = ALT_MIN;
            n_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_kel     <= w_kel_s[KEL_W-1:0];
            r_time[0] <= w_ts;
            r_zp[0]   <= (w_p == '0);
            r_z0[0]   <= (r_p0 == '0);
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (w_en[k]) begin
                r_time[k] <= r_time[k-1];
            end
        end
        for (int k = 1; k < DEPTH - 1; k++) begin
            if (w_en[k]) begin
                r_zp[k] <= r_zp[k-1];
                r_z0[k] <= r_z0[k-1];
            end
        end
        if (w_en[1]) begin
            r_ks[1] <= KS_W'(r_kel) * KS_W'(SCALE_Q16);
        end
        for (int k = 2; k <= LN_STAGES; k++) begin
            if (w_en[k]) begin
                r_ks[k] <= r_ks[k-1];
            end
        end
        if (w_en[5]) begin
            r_neg5 <= w_diff[LN_W];
            r_mag  <= w_diff[LN_W] ? LN_W'(-w_diff) : w_diff[LN_W-1:0];
        end
        if (w_en[6]) begin
            r_neg6 <= r_neg5;
            r_prod <= PROD_W'(r_ks[LN_STAGES]) * PROD_W'(r_mag);
        end
        if (w_en[7]) begin
            r_alt <= n_alt;
            r_sat <= n_sat;
        end
    end

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, r_time[DEPTH-1], r_alt};
    assign o_m_axis_tuser = r_sat;

endmodule

@@ hw/rtl/baro_checker.sv @@
// Port-level assertions for barometric_altitude, attached by the bind below.
// Depends on baro_pkg for the altitude limits and the pipeline depth.
`timescale 1ns / 1ps

module baro_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [baro_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser
);
    import baro_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 2);

    logic signed [ALT_W-1:0] w_alt;
    logic                    w_in_acc;
    logic                    w_out_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;

    assign w_alt     = o_m_axis_tdata[ALT_W-1:0];
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc && !w_out_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!w_in_acc && w_out_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A result held at the output keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // A saturated result sits on a limit; any other lies inside the range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser ? (w_alt == ALT_MIN || w_alt == ALT_MAX)
                            : (w_alt >= ALT_MIN && w_alt <= ALT_MAX)))
        else $error("altitude inconsistent with saturation flag");

    // When the output can move, the input side never stalls.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled while output register is free");

    // No more items in flight than there are stages, and a shown result is one.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(DEPTH)) && (!o_m_axis_tvalid || r_cnt != '0))
        else $error("item count in pipeline out of bounds");

endmodule

bind barometric_altitude baro_checker u_baro_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
